@@ sv/ckre_pkg.sv @@
package ckre_pkg;

    localparam int CODE_W = 10;

    // default sizes
    localparam int TABLE_DEPTH_DEF    = 32;
    localparam int HELD_DEPTH_DEF     = 10;
    localparam int MODS_PER_ENTRY_DEF = 4;
    localparam int MODS_MAX           = 4;

    // result kinds
    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_SYNC = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // key values
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;
    localparam logic [1:0] VAL_REPEAT  = 2'd2;
    localparam logic [1:0] VAL_INVALID = 2'd3;

    // key codes
    localparam logic [CODE_W-1:0] CODE_LCTRL  = 10'd29;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 10'd42;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 10'd54;
    localparam logic [CODE_W-1:0] CODE_LALT   = 10'd56;
    localparam logic [CODE_W-1:0] CODE_RCTRL  = 10'd97;
    localparam logic [CODE_W-1:0] CODE_RALT   = 10'd100;
    localparam logic [CODE_W-1:0] CODE_LMETA  = 10'd125;
    localparam logic [CODE_W-1:0] CODE_RMETA  = 10'd126;
    localparam logic [CODE_W-1:0] CODE_FN     = 10'd464;
    localparam logic [CODE_W-1:0] CODE_ASSIST = 10'd583;
    localparam logic [CODE_W-1:0] SYN_REPORT  = 10'd0;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic       func;
        t_code      key_code;
        logic [1:0] key_value;
        t_code      entry_original;
        t_code      entry_remap;
        logic [2:0] entry_mod_count;
        t_code      entry_mod_first;
        t_code      entry_mod_second;
        t_code      entry_mod_third;
        t_code      entry_mod_fourth;
        logic       entry_preserve;
    } t_in;

    typedef struct packed {
        logic [1:0] out_kind;
        t_code      out_code;
        logic [1:0] out_value;
        logic       load_ok;
        logic       last;
    } t_out;

    // controller commands
    typedef struct packed {
        logic scan_clr;
        logic scan;
        logic rel;
        logic key;
        logic sync;
        logic load;
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic is_load;
        logic invalid;
        logic scan_done;
        logic rel_pend;
        logic rel_last;
    } t_sts;

    function automatic logic is_mod(input t_code k);
        return k == CODE_LCTRL || k == CODE_LALT || k == CODE_LSHIFT ||
               k == CODE_LMETA || k == CODE_RCTRL || k == CODE_RALT ||
               k == CODE_RSHIFT || k == CODE_RMETA || k == CODE_FN ||
               k == CODE_ASSIST;
    endfunction

endpackage

@@ sv/ckre_ctrl.sv @@
module ckre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ckre_pkg::t_sts i_sts,
    output ckre_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ckre_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_LOAD, S_SCAN, S_REL, S_KEY, S_SYNC
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // next state
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_DECODE;
                    n_busy  = 1'b1;
                end
            end
            S_DECODE: begin
                if (i_sts.is_load) n_state = S_LOAD;
                else if (i_sts.invalid) n_state = S_SYNC;
                else n_state = S_SCAN;
            end
            S_LOAD: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = i_sts.rel_pend ? S_REL : S_KEY;
            end
            S_REL: begin
                if (i_sts.rel_last) n_state = S_KEY;
            end
            S_KEY: n_state = S_SYNC;
            S_SYNC: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    // commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.scan_clr = (r_state == S_DECODE);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.rel      = (r_state == S_REL);
        o_cmd.key      = (r_state == S_KEY);
        o_cmd.sync     = (r_state == S_SYNC);
        o_cmd.load     = (r_state == S_LOAD);
    end

    assign o_busy = r_busy;

endmodule

@@ sv/ckre_dp.sv @@
module ckre_dp #(
    parameter int TABLE_DEPTH    = ckre_pkg::TABLE_DEPTH_DEF,
    parameter int HELD_DEPTH     = ckre_pkg::HELD_DEPTH_DEF,
    parameter int MODS_PER_ENTRY = ckre_pkg::MODS_PER_ENTRY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  ckre_pkg::t_in  i_item,
    input  ckre_pkg::t_cmd i_cmd,
    output ckre_pkg::t_sts o_sts,
    output logic           o_strobe,
    output ckre_pkg::t_out o_result
);
    import ckre_pkg::*;

    localparam int ECW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int HCW   = $clog2(HELD_DEPTH + 1);
    localparam int HIW   = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int MW    = (MODS_PER_ENTRY > 1) ? $clog2(MODS_PER_ENTRY) : 1;
    localparam int WORD_W = 24 + MODS_PER_ENTRY * CODE_W;

    // entry table memory: {mods, preserve, count, remap, original}
    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    t_in              r_in;
    logic [ECW-1:0]   r_ecnt;
    logic [TABLE_DEPTH-1:0] r_marks;
    t_code            r_held [HELD_DEPTH];
    logic [HCW-1:0]   r_hcnt;

    // scan pipeline
    logic [ECW-1:0]   r_idx;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic [WORD_W-1:0] r_rd_data;

    // scan results
    logic             r_ex_found;
    logic [IW-1:0]    r_ex_idx;
    t_code            r_ex_remap;
    logic [2:0]       r_ex_nm;
    logic             r_ex_pres;
    t_code            r_ex_mods [MODS_PER_ENTRY];
    logic             r_mk_found;
    logic [IW-1:0]    r_mk_idx;
    t_code            r_mk_remap;
    logic [MW-1:0]    r_m;

    logic             r_strobe;
    t_out             r_out;
    t_out             n_out;

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_accept) r_in <= i_item;
    end

    // append word build
    logic [2:0]  ld_cnt;
    t_code       in_mods [MODS_MAX];
    logic [MODS_PER_ENTRY*CODE_W-1:0] ld_mods;
    logic        tbl_full;

    always_comb begin
        in_mods[0] = r_in.entry_mod_first;
        in_mods[1] = r_in.entry_mod_second;
        in_mods[2] = r_in.entry_mod_third;
        in_mods[3] = r_in.entry_mod_fourth;
        ld_cnt = (r_in.entry_mod_count > 3'(MODS_PER_ENTRY)) ? 3'(MODS_PER_ENTRY)
                                                            : r_in.entry_mod_count;
        for (int m = 0; m < MODS_PER_ENTRY; m++) begin
            ld_mods[m*CODE_W +: CODE_W] = (3'(m) < ld_cnt) ? in_mods[m] : '0;
        end
        tbl_full = (r_ecnt >= ECW'(TABLE_DEPTH));
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !tbl_full) begin
            mem[r_ecnt[IW-1:0]] <= {ld_mods, r_in.entry_preserve, ld_cnt,
                                    r_in.entry_remap, r_in.entry_original};
        end
        r_rd_data <= mem[r_idx[IW-1:0]];
    end

    // entry decode and compare
    t_code      c_orig, c_remap;
    logic [2:0] c_nm;
    logic       c_pres, c_exact, c_marked;
    t_code      c_mods [MODS_PER_ENTRY];

    always_comb begin
        c_orig  = r_rd_data[CODE_W-1:0];
        c_remap = r_rd_data[2*CODE_W-1:CODE_W];
        c_nm    = r_rd_data[22:20];
        c_pres  = r_rd_data[23];
        c_exact = (c_orig == r_in.key_code) && (8'(c_nm) == 8'(r_hcnt));
        for (int m = 0; m < MODS_PER_ENTRY; m++) begin
            c_mods[m] = r_rd_data[24 + m*CODE_W +: CODE_W];
            if (m < HELD_DEPTH) begin
                if (3'(m) < c_nm && c_mods[m] != r_held[m]) c_exact = 1'b0;
            end
        end
        c_marked = (c_orig == r_in.key_code) && r_marks[r_rd_idx];
    end

    // table scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_ex_found <= 1'b0;
            r_mk_found <= 1'b0;
            r_m        <= '0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= (r_idx < r_ecnt);
            r_rd_idx <= r_idx[IW-1:0];
            if (r_idx < r_ecnt) r_idx <= r_idx + 1'b1;
            if (r_rd_vld && c_exact && !r_ex_found) begin
                r_ex_found <= 1'b1;
                r_ex_idx   <= r_rd_idx;
                r_ex_remap <= c_remap;
                r_ex_nm    <= c_nm;
                r_ex_pres  <= c_pres;
                r_ex_mods  <= c_mods;
            end
            if (r_rd_vld && c_marked && !r_mk_found) begin
                r_mk_found <= 1'b1;
                r_mk_idx   <= r_rd_idx;
                r_mk_remap <= c_remap;
            end
        end else if (i_cmd.rel) begin
            r_m <= r_m + 1'b1;
        end
    end

    // status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.is_load   = r_in.func;
        o_sts.invalid   = (r_in.key_value == VAL_INVALID);
        o_sts.scan_done = !r_rd_vld && (r_idx >= r_ecnt);
        o_sts.rel_pend  = r_ex_found && !r_ex_pres && (r_ex_nm != 3'd0);
        o_sts.rel_last  = (3'(r_m) == r_ex_nm - 3'd1);
    end

    // key decisions
    logic  use_mk;
    t_code sent;
    always_comb begin
        use_mk = !r_ex_found && (r_in.key_value != VAL_PRESS) && r_mk_found;
        sent   = r_ex_found ? r_ex_remap : (use_mk ? r_mk_remap : r_in.key_code);
    end

    // repeat marks and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_ecnt  <= '0;
        end else begin
            if (i_cmd.load && !tbl_full) begin
                r_marks[r_ecnt[IW-1:0]] <= 1'b0;
                r_ecnt <= r_ecnt + 1'b1;
            end
            if (i_cmd.key) begin
                if (r_ex_found && r_in.key_value == VAL_REPEAT)
                    r_marks[r_ex_idx] <= 1'b1;
                else if (use_mk && r_in.key_value == VAL_RELEASE)
                    r_marks[r_mk_idx] <= 1'b0;
            end
        end
    end

    // held modifier list update
    logic  h_hit, h_seen;
    t_code n_held [HELD_DEPTH];
    always_comb begin
        h_seen = 1'b0;
        for (int j = 0; j < HELD_DEPTH; j++) begin
            h_seen = h_seen || ((r_held[j] == r_in.key_code) && (HCW'(j) < r_hcnt));
            if (h_seen) n_held[j] = (j + 1 < HELD_DEPTH) ? r_held[(j + 1) % HELD_DEPTH] : '0;
            else n_held[j] = r_held[j];
        end
        h_hit = h_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= '0;
            for (int j = 0; j < HELD_DEPTH; j++) r_held[j] <= '0;
        end else if (i_cmd.key && is_mod(r_in.key_code)) begin
            if (r_in.key_value == VAL_RELEASE && h_hit) begin
                r_held <= n_held;
                r_hcnt <= r_hcnt - 1'b1;
            end else if (r_in.key_value == VAL_PRESS && r_hcnt < HCW'(HELD_DEPTH)) begin
                r_held[r_hcnt[HIW-1:0]] <= r_in.key_code;
                r_hcnt <= r_hcnt + 1'b1;
            end
        end
    end

    // next result word
    always_comb begin
        n_out = '0;
        if (i_cmd.load) begin
            n_out.out_kind = KIND_LOAD;
            n_out.load_ok  = !tbl_full;
            n_out.last     = 1'b1;
        end else if (i_cmd.rel) begin
            n_out.out_kind  = KIND_KEY;
            n_out.out_code  = r_ex_mods[r_m];
            n_out.out_value = VAL_RELEASE;
        end else if (i_cmd.key) begin
            n_out.out_kind  = KIND_KEY;
            n_out.out_code  = sent;
            n_out.out_value = r_in.key_value;
        end else if (i_cmd.sync) begin
            n_out.out_kind = KIND_SYNC;
            n_out.out_code = SYN_REPORT;
            n_out.last     = 1'b1;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load || i_cmd.rel || i_cmd.key || i_cmd.sync;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ sv/chorded_key_remap_engine_core.sv @@
// Chorded key remap engine.
// Input: an item is taken when start is high and busy is low. func 0 is a key
// event, func 1 appends an entry to the remap table.
// Output: each result word appears for one cycle with o_strobe high; last
// marks the final word of an item. The receiver cannot hold results off.
// Sequence: an append gives only its status word, and an invalid value gives
// only the sync word. A key event walks the table one entry a cycle through
// the registered memory read, then sends any modifier releases, the key word
// and the sync word.
// busy drops as the last word appears, so the next item can be taken at the
// edge that takes that word.
// Reset: clears the entry count, repeat marks and held modifier list; table
// contents are undefined until written.
module chorded_key_remap_engine_core #(
    parameter int TABLE_DEPTH    = ckre_pkg::TABLE_DEPTH_DEF,
    parameter int HELD_DEPTH     = ckre_pkg::HELD_DEPTH_DEF,
    parameter int MODS_PER_ENTRY = ckre_pkg::MODS_PER_ENTRY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ckre_pkg::t_in  i_item,
    output logic           o_strobe,
    output ckre_pkg::t_out o_result
);
    import ckre_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic accept;

    assign accept = start && !busy;

    // sequencer
    ckre_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // table, held list and result datapath
    ckre_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .HELD_DEPTH     (HELD_DEPTH),
        .MODS_PER_ENTRY (MODS_PER_ENTRY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ sv/ckre_checker.sv @@
module ckre_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input ckre_pkg::t_out o_result
);
    import ckre_pkg::*;

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");

    // the block goes idle exactly as the final word shows
    a_fell_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_result.last) else $error("idle without last word");

    // words before the last come while busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy) else $error("word while idle");

    // last words are only sync or load status
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> o_result.out_kind == KIND_SYNC ||
                                      o_result.out_kind == KIND_LOAD)
        else $error("bad last word kind");

endmodule

bind chorded_key_remap_engine_core ckre_checker u_ckre_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
